>>> hdl/mstt_pkg.sv
// Package for the MAC signal tracking table: payload structs, codes and sizes.
// Used by every module of the block; depends on nothing.
package mstt_pkg;

	localparam int unsigned TableDepthDefault = 16;
	localparam logic [4:0] TableSizeReset = 5'd16;

	localparam logic [1:0] OpObserve = 2'd0;
	localparam logic [1:0] OpFlush   = 2'd1;
	localparam logic [1:0] OpClear   = 2'd2;
	localparam logic [1:0] OpUnused  = 2'd3;

	localparam logic [1:0] KindRepeat = 2'd0;
	localparam logic [1:0] KindPeak   = 2'd1;
	localparam logic [1:0] KindLatest = 2'd2;
	localparam logic [1:0] KindEnd    = 2'd3;

	typedef struct packed {
		logic [1:0]         op;
		logic [47:0]        mac_addr;
		logic signed [7:0]  signal_level;
		logic [31:0]        time_sec;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         report_kind;
		logic [47:0]        entry_mac;
		logic signed [7:0]  first_signal;
		logic signed [7:0]  peak_signal;
		logic signed [7:0]  latest_signal;
		logic [31:0]        first_time;
		logic [31:0]        peak_time;
		logic [31:0]        latest_time;
		logic               last_of_run;
	} out_item_t;

	// A classified command handed from the front end to the table engine.
	typedef struct packed {
		logic               is_observe;
		logic               is_flush;
		logic               is_clear;
		logic [47:0]        mac_addr;
		logic signed [7:0]  signal_level;
		logic [31:0]        time_sec;
	} cmd_t;

endpackage

>>> hdl/mstt_front.sv
// Front end: accepts input transfers, classifies their codes, queues commands.
// Depends on mstt_pkg.
module mstt_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  mstt_pkg::in_item_t  in_item,
	output logic                cmd_valid,
	input  logic                cmd_pop,
	output mstt_pkg::cmd_t      cmd
);

	mstt_pkg::cmd_t q_mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	mstt_pkg::cmd_t new_cmd;

	assign in_stall  = (count_q == 2'd2);
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = q_mem_q[rd_ptr_q];

	always_comb begin
		new_cmd.is_observe   = (in_item.op == mstt_pkg::OpObserve);
		new_cmd.is_flush     = (in_item.op == mstt_pkg::OpFlush);
		new_cmd.is_clear     = (in_item.op == mstt_pkg::OpClear);
		new_cmd.mac_addr     = in_item.mac_addr;
		new_cmd.signal_level = in_item.signal_level;
		new_cmd.time_sec     = in_item.time_sec;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, cmd_pop};
		end
	end

endmodule

>>> hdl/mstt_engine.sv
// Table engine: walks the entries one per cycle for search, and entry by entry for flush.
// Depends on mstt_pkg; fed by mstt_front.
module mstt_engine #(
	parameter int unsigned TABLE_DEPTH = mstt_pkg::TableDepthDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [4:0]          table_size,
	input  logic                cmd_valid,
	output logic                cmd_pop,
	input  mstt_pkg::cmd_t      cmd,
	output logic                out_valid,
	input  logic                out_stall,
	output mstt_pkg::out_item_t out_item
);

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SEARCH = 6'b000010,
		ST_UPDATE = 6'b000100,
		ST_FLUSH  = 6'b001000,
		ST_EMIT   = 6'b010000,
		ST_END    = 6'b100000
	} state_t;

	logic [47:0] mac_mem   [TABLE_DEPTH];
	logic [7:0]  fsig_mem  [TABLE_DEPTH];
	logic [7:0]  psig_mem  [TABLE_DEPTH];
	logic [7:0]  lsig_mem  [TABLE_DEPTH];
	logic [31:0] ftime_mem [TABLE_DEPTH];
	logic [31:0] ptime_mem [TABLE_DEPTH];
	logic [31:0] ltime_mem [TABLE_DEPTH];
	logic        rep_mem   [TABLE_DEPTH];

	state_t      state_q;
	logic [IW-1:0] idx_q, wptr_q;
	logic [CW-1:0] occ_q;
	logic          hit_q, peak_pend_q, late_pend_q;
	logic          out_valid_q;
	mstt_pkg::out_item_t out_q;

	logic [CW-1:0] eff_size, lim;
	logic          out_free;
	logic [IW:0]   idx_next;

	always_comb begin
		if (table_size == 5'd0) begin
			eff_size = CW'(1);
		end else if ({27'd0, table_size} > 32'(TABLE_DEPTH)) begin
			eff_size = CW'(TABLE_DEPTH);
		end else begin
			eff_size = CW'(table_size);
		end
		lim = (occ_q < eff_size) ? occ_q : eff_size;
	end

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign idx_next  = {1'b0, idx_q} + 1'b1;
	assign cmd_pop   = (state_q == ST_IDLE) && cmd_valid &&
		!cmd.is_flush && !cmd.is_observe ? 1'b1 :
		((state_q == ST_UPDATE) && (!hit_q || rep_mem[idx_q] || out_free)) ||
		((state_q == ST_END) && out_free);

	function automatic mstt_pkg::out_item_t entry_item(input logic [1:0] kind,
		input logic [47:0] m, input logic [7:0] fs, input logic [7:0] ps,
		input logic [7:0] ls, input logic [31:0] ft, input logic [31:0] pt,
		input logic [31:0] lt, input logic last);
		mstt_pkg::out_item_t r;
		r.report_kind   = kind;
		r.entry_mac     = m;
		r.first_signal  = fs;
		r.peak_signal   = ps;
		r.latest_signal = ls;
		r.first_time    = ft;
		r.peak_time     = pt;
		r.latest_time   = lt;
		r.last_of_run   = last;
		return r;
	endfunction

	// Table writes: an update on a hit, a fresh entry on a miss.
	always_ff @(posedge clk) begin
		if (state_q == ST_UPDATE && cmd_pop) begin
			if (hit_q) begin
				if ($signed(cmd.signal_level) > $signed(psig_mem[idx_q])) begin
					psig_mem[idx_q]  <= cmd.signal_level;
					ptime_mem[idx_q] <= cmd.time_sec;
				end
				lsig_mem[idx_q]  <= cmd.signal_level;
				ltime_mem[idx_q] <= cmd.time_sec;
				rep_mem[idx_q]   <= 1'b1;
			end else begin
				mac_mem[idx_q]   <= cmd.mac_addr;
				fsig_mem[idx_q]  <= cmd.signal_level;
				psig_mem[idx_q]  <= cmd.signal_level;
				lsig_mem[idx_q]  <= cmd.signal_level;
				ftime_mem[idx_q] <= cmd.time_sec;
				ptime_mem[idx_q] <= cmd.time_sec;
				ltime_mem[idx_q] <= cmd.time_sec;
				rep_mem[idx_q]   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (state_q == ST_UPDATE && hit_q && !rep_mem[idx_q]) begin
				out_q <= entry_item(mstt_pkg::KindRepeat, mac_mem[idx_q],
					fsig_mem[idx_q],
					($signed(cmd.signal_level) > $signed(psig_mem[idx_q])) ?
						cmd.signal_level : psig_mem[idx_q],
					cmd.signal_level, ftime_mem[idx_q],
					($signed(cmd.signal_level) > $signed(psig_mem[idx_q])) ?
						cmd.time_sec : ptime_mem[idx_q],
					cmd.time_sec, 1'b1);
			end else if (state_q == ST_EMIT) begin
				out_q <= entry_item(peak_pend_q ? mstt_pkg::KindPeak : mstt_pkg::KindLatest,
					mac_mem[idx_q], fsig_mem[idx_q], psig_mem[idx_q], lsig_mem[idx_q],
					ftime_mem[idx_q], ptime_mem[idx_q], ltime_mem[idx_q], 1'b0);
			end else if (state_q == ST_END) begin
				out_q <= entry_item(mstt_pkg::KindEnd, '0, '0, '0, '0, '0, '0, '0, 1'b1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			wptr_q      <= '0;
			occ_q       <= '0;
			hit_q       <= 1'b0;
			peak_pend_q <= 1'b0;
			late_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (cmd_valid) begin
						if (cmd.is_clear) begin
							occ_q  <= '0;
							wptr_q <= '0;
						end else if (cmd.is_observe) begin
							state_q <= ST_SEARCH;
						end else if (cmd.is_flush) begin
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_SEARCH: begin
					// A miss on the last occupied entry ends the search without
					// stepping the index past the table.
					if (({1'b0, idx_q} >= (IW+1)'(lim)) ||
						((mac_mem[idx_q] != cmd.mac_addr) &&
						(idx_next >= (IW+1)'(lim)))) begin
						hit_q   <= 1'b0;
						idx_q   <= ({1'b0, wptr_q} < (IW+1)'(eff_size)) ? wptr_q : '0;
						state_q <= ST_UPDATE;
					end else if (mac_mem[idx_q] == cmd.mac_addr) begin
						hit_q   <= 1'b1;
						state_q <= ST_UPDATE;
					end else begin
						idx_q <= idx_next[IW-1:0];
					end
				end
				ST_UPDATE: begin
					if (cmd_pop) begin
						state_q <= ST_IDLE;
						if (hit_q) begin
							if (!rep_mem[idx_q]) begin
								out_valid_q <= 1'b1;
							end
						end else begin
							wptr_q <= ((IW+1)'(idx_next) >= (IW+1)'(eff_size)) ? '0
								: idx_next[IW-1:0];
							occ_q <= (occ_q < eff_size) ? occ_q + 1'b1 : eff_size;
						end
					end
				end
				ST_FLUSH: begin
					if ({1'b0, idx_q} >= (IW+1)'(lim)) begin
						state_q <= ST_END;
					end else begin
						peak_pend_q <= ftime_mem[idx_q] != ptime_mem[idx_q];
						late_pend_q <= (ptime_mem[idx_q] != ltime_mem[idx_q]) &&
							(ftime_mem[idx_q] != ltime_mem[idx_q]);
						state_q     <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!peak_pend_q && !late_pend_q) begin
						idx_q   <= idx_next[IW-1:0];
						state_q <= ({1'b0, idx_q} + 1'b1 >= (IW+1)'(lim)) ? ST_END : ST_FLUSH;
					end else if (out_free) begin
						out_valid_q <= 1'b1;
						if (peak_pend_q) begin
							peak_pend_q <= 1'b0;
						end else begin
							late_pend_q <= 1'b0;
						end
					end
				end
				ST_END: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> hdl/mac_signal_tracking_table.sv
// Top level of the MAC signal tracking table: APB register, front end, engine.
// Depends on mstt_pkg, mstt_front and mstt_engine.
//
//  channel  | handshake                | payload
//  in       | in_valid / in_stall      | in_item  (mstt_pkg::in_item_t)
//  out      | out_valid / out_stall    | out_item (mstt_pkg::out_item_t)
//  config   | psel/penable/pwrite      | paddr, pwdata, prdata
//
// An observe searches the entries in turn, then updates a hit or writes a new entry;
// a flush visits each entry through the flush and emit states, sends its reports,
// then the end marker. The walk over the entry registers is sequential.
// Reset clears the pointer, occupancy and handshake state; entries stay unknown.
// A stalled output holds the engine when it has a report to send; two commands queue in front meanwhile.
module mac_signal_tracking_table #(
	parameter int unsigned TABLE_DEPTH = mstt_pkg::TableDepthDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  mstt_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output mstt_pkg::out_item_t out_item,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [1:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	logic [4:0]     table_size_q;
	logic           cmd_valid, cmd_pop;
	mstt_pkg::cmd_t cmd;

	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {27'd0, table_size_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= mstt_pkg::TableSizeReset;
		end else if (psel && penable && pwrite && paddr == 2'd0) begin
			table_size_q <= pwdata[4:0];
		end
	end

	mstt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd)
	);

	mstt_engine #(.TABLE_DEPTH(TABLE_DEPTH)) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.table_size (table_size_q),
		.cmd_valid  (cmd_valid),
		.cmd_pop    (cmd_pop),
		.cmd        (cmd),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item)
	);

endmodule
